FILE: rtl/cbq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cbq_pkg;

  localparam int MaxSections = 8;
  localparam int TapsPerSection = 5;
  localparam int TableDepth = MaxSections * TapsPerSection;
  localparam int CoefAddrW = $clog2(TableDepth);
  localparam int SecW = $clog2(MaxSections);

  localparam int SampleW = 16;
  localparam int CoefW = 20;
  localparam int SigW = 32;
  localparam int IdxW = 6;
  localparam int SecCfgW = 4;
  localparam int ProdW = SigW + CoefW;
  localparam int AccW = 56;

  typedef enum logic [0:0] {
    CfgGain     = 1'b0,
    CfgSections = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ModeFilter = 1'b0,
    ModeCoef   = 1'b1
  } mode_e;

  // source of the multiplier's signal operand
  typedef enum logic [1:0] {
    OpSample = 2'd0,
    OpSig    = 2'd1,
    OpY      = 2'd2
  } opa_e;

  // what happens to the accumulator in one step
  typedef enum logic [1:0] {
    AccLoad  = 2'd0,
    AccAdd   = 2'd1,
    AccSub   = 2'd2,
    AccHold  = 2'd3
  } accop_e;

  typedef enum logic [3:0] {
    StIdle,
    StGainMul,
    StGainRnd,
    StB0Mul,
    StYRnd,
    StA1Mul,
    StB1Mul,
    StD1Rnd,
    StB2Mul,
    StA2Mul,
    StD2Rnd,
    StNext,
    StOut
  } state_e;

  typedef struct packed {
    logic                 start;
    opa_e                 opa;
    logic [2:0]           tap;
    logic                 mul_en;
    accop_e               acc_op;
    logic                 acc_d1;
    logic                 gain_rnd;
    logic                 y_wr;
    logic                 d1_wr;
    logic                 d2_wr;
    logic                 sec_inc;
    logic                 out_load;
  } cbq_cmd_t;

  typedef struct packed {
    logic more_sections;
  } cbq_sts_t;

  // round to nearest (ties up) by 2^15 in gain mode, else by 2^16, then saturate to 32 bits
  function automatic logic signed [SigW-1:0] round_sat(input logic signed [AccW-1:0] v,
                                                      input logic gain_mode);
    logic signed [AccW-1:0] w;
    logic signed [AccW-1:0] s;
    begin
      if (gain_mode) begin
        w = v + AccW'(signed'(64'sd16384));
        s = w >>> 15;
      end else begin
        w = v + AccW'(signed'(64'sd32768));
        s = w >>> 16;
      end
      if (s > AccW'(signed'(64'sd2147483647))) begin
        round_sat = 32'sh7fffffff;
      end else if (s < -AccW'(signed'(64'sd2147483648))) begin
        round_sat = 32'sh80000000;
      end else begin
        round_sat = s[SigW-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cbq_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cbq_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] sample;
  logic [5:0]  coef_index;
  logic [19:0] coef_value;
  modport source (output valid, mode, sample, coef_index, coef_value, input ready);
  modport sink (input valid, mode, sample, coef_index, coef_value, output ready);
endinterface

interface cbq_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered_sample;
  modport source (output valid, filtered_sample, input ready);
  modport sink (input valid, filtered_sample, output ready);
endinterface

interface cbq_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/cascaded_biquad_iir_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Cascaded transposed direct form II biquad filter. A filter item (mode 0)
// runs through the N sections in use (at most eight) on the one shared 32x20
// multiplier, which forms five products per section; the result waits in an
// output register and the next item is accepted meanwhile, finishing its last
// step only once that result is taken. A coefficient item (mode 1) is written
// to the table on acceptance. Configuration writes land at once; write them
// only while idle.
module cascaded_biquad_iir_filter (
  input  wire    clk_i,
  input  wire    rst_ni,
  cbq_in_if.sink     in_ch,
  cbq_out_if.source  out_ch,
  cbq_cfg_if.sink    cfg_ch
);
  import cbq_pkg::*;

  cbq_cmd_t cmd;
  cbq_sts_t sts;
  logic in_ready;
  logic out_valid_q;
  logic [SampleW-1:0] out_data_q, result;
  logic [CoefW-1:0] gain_q;
  logic [SecCfgW-1:0] sections_q;
  logic coef_we;

  assign in_ch.ready = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign coef_we = in_ch.valid && in_ready && in_ch.mode == ModeCoef;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 20'sd65536;
      sections_q <= 4'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CfgGain:     gain_q <= cfg_ch.data;
        CfgSections: sections_q <= cfg_ch.data[SecCfgW-1:0];
        default: begin
        end
      endcase
    end
  end

  cbq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_mode_i  (in_ch.mode),
    .in_ready_o (in_ready),
    .out_busy_i (out_valid_q),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cbq_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .coef_we_i  (coef_we),
    .coef_idx_i (in_ch.coef_index),
    .coef_val_i (in_ch.coef_value),
    .sample_i   (in_ch.sample),
    .gain_i     (gain_q),
    .sections_i (sections_q),
    .result_o   (result)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd.out_load) out_data_q <= result;
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.filtered_sample = out_data_q;
endmodule
`default_nettype wire

FILE: rtl/cbq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module cbq_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_mode_i,
  output logic                in_ready_o,
  input  wire                 out_busy_i,
  input  cbq_pkg::cbq_sts_t   sts_i,
  output cbq_pkg::cbq_cmd_t   cmd_o
);
  import cbq_pkg::*;

  state_e state_q, state_d;

  // accept whenever idle; a waiting result is held in the output register
  assign in_ready_o = (state_q == StIdle);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o && in_mode_i == ModeFilter) state_d = StGainMul;
      end
      StGainMul: state_d = StGainRnd;
      StGainRnd: state_d = sts_i.more_sections ? StB0Mul : StOut;
      StB0Mul:   state_d = StYRnd;
      StYRnd:    state_d = StA1Mul;
      StA1Mul:   state_d = StB1Mul;
      StB1Mul:   state_d = StD1Rnd;
      StD1Rnd:   state_d = StB2Mul;
      StB2Mul:   state_d = StA2Mul;
      StA2Mul:   state_d = StD2Rnd;
      StD2Rnd:   state_d = StNext;
      StNext:    state_d = sts_i.more_sections ? StB0Mul : StOut;
      StOut:     state_d = out_busy_i ? StOut : StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // outputs; the multiplier result is registered, accumulate in the step after
  // the coefficient read is registered, so the step before each multiply addresses its tap
  always_comb begin
    cmd_o = '0;
    cmd_o.acc_op = AccHold;
    cmd_o.opa = OpSig;
    case (state_q)
      StIdle: begin
        cmd_o.start = in_valid_i && in_ready_o && in_mode_i == ModeFilter;
      end
      StGainMul: begin
        cmd_o.opa = OpSample;
        cmd_o.mul_en = 1'b1;
      end
      StGainRnd: begin
        cmd_o.acc_op = AccLoad;
        cmd_o.gain_rnd = 1'b1;
      end
      StB0Mul: begin
        cmd_o.tap = 3'd0;
        cmd_o.mul_en = 1'b1;
      end
      StYRnd: begin
        cmd_o.tap = 3'd3;
        cmd_o.acc_op = AccLoad;
        cmd_o.acc_d1 = 1'b1;
        cmd_o.y_wr = 1'b1;
      end
      StA1Mul: begin
        cmd_o.opa = OpY;
        cmd_o.tap = 3'd1;
        cmd_o.mul_en = 1'b1;
      end
      StB1Mul: begin
        cmd_o.tap = 3'd1;
        cmd_o.mul_en = 1'b1;
        cmd_o.acc_op = AccSub;
      end
      StD1Rnd: begin
        cmd_o.tap = 3'd2;
        cmd_o.acc_op = AccAdd;
        cmd_o.d1_wr = 1'b1;
      end
      StB2Mul: begin
        cmd_o.tap = 3'd4;
        cmd_o.mul_en = 1'b1;
      end
      StA2Mul: begin
        cmd_o.opa = OpY;
        cmd_o.tap = 3'd4;
        cmd_o.mul_en = 1'b1;
        cmd_o.acc_op = AccLoad;
      end
      StD2Rnd: begin
        cmd_o.acc_op = AccSub;
        cmd_o.d2_wr = 1'b1;
        cmd_o.sec_inc = 1'b1;
      end
      StNext: begin
      end
      StOut: begin
        cmd_o.out_load = !out_busy_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/cbq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module cbq_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cbq_pkg::cbq_cmd_t            cmd_i,
  output cbq_pkg::cbq_sts_t            sts_o,
  input  wire                          coef_we_i,
  input  wire  [cbq_pkg::IdxW-1:0]     coef_idx_i,
  input  wire  [cbq_pkg::CoefW-1:0]    coef_val_i,
  input  wire  [cbq_pkg::SampleW-1:0]  sample_i,
  input  wire  [cbq_pkg::CoefW-1:0]    gain_i,
  input  wire  [cbq_pkg::SecCfgW-1:0]  sections_i,
  output logic [cbq_pkg::SampleW-1:0]  result_o
);
  import cbq_pkg::*;

  logic [CoefW-1:0] coef_mem [TableDepth];
  logic signed [SigW-1:0] d1_q [MaxSections];
  logic signed [SigW-1:0] d2_q [MaxSections];
  logic signed [SampleW-1:0] sample_q;
  logic signed [SigW-1:0] sig_q, y_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic [SecW:0] sec_q, n_lim;
  logic [SecW-1:0] sec_idx;
  logic [CoefAddrW-1:0] rd_addr;
  logic signed [CoefW-1:0] coef_q;
  logic signed [SigW-1:0] opa;
  logic signed [CoefW-1:0] opb;
  logic signed [SigW-1:0] rnd;
  logic signed [AccW-1:0] prod_ext, d_ext;

  assign sec_idx = sec_q[SecW-1:0];

  // section count clipped to the table size
  assign n_lim = (sections_i > SecCfgW'(MaxSections)) ? (SecW+1)'(MaxSections)
                                                      : (SecW+1)'(sections_i);
  assign sts_o.more_sections = sec_q < n_lim;

  // coefficient table, registered read
  assign rd_addr = CoefAddrW'(32'(sec_idx) * TapsPerSection + 32'(cmd_i.tap));
  always_ff @(posedge clk_i) begin
    if (coef_we_i && coef_idx_i < IdxW'(TableDepth)) begin
      coef_mem[coef_idx_i[CoefAddrW-1:0]] <= coef_val_i;
    end
  end
  always_ff @(posedge clk_i) begin
    coef_q <= signed'(coef_mem[rd_addr]);
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.opa)
      OpSample: opa = SigW'(sample_q);
      OpY:      opa = y_q;
      default:  opa = sig_q;
    endcase
    opb = (cmd_i.opa == OpSample) ? signed'(gain_i) : coef_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ProdW'(opa) * ProdW'(opb);
    end
  end

  // accumulator at Q.32 (Q.31 for the gain product) with optional delay term
  assign prod_ext = AccW'(prod_q);
  assign d_ext = cmd_i.acc_d1 ? (AccW'(d1_q[sec_idx]) <<< 16)
                              : (AccW'(d2_q[sec_idx]) <<< 16);
  always_comb begin
    case (cmd_i.acc_op)
      AccLoad: acc_d = cmd_i.acc_d1 ? d_ext + prod_ext : prod_ext;
      AccAdd:  acc_d = acc_q + prod_ext;
      AccSub:  acc_d = acc_q - prod_ext;
      default: acc_d = acc_q;
    endcase
    if (cmd_i.acc_op == AccSub && cmd_i.tap == 3'd1) begin
      acc_d = d_ext - prod_ext;
    end
  end
  assign rnd = round_sat(acc_d, cmd_i.gain_rnd);

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.start) sample_q <= signed'(sample_i);
    if (cmd_i.gain_rnd) sig_q <= rnd;
    if (cmd_i.y_wr) y_q <= rnd;
    if (cmd_i.sec_inc) sig_q <= y_q;
  end

  // delay state and section counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSections; i++) begin
        d1_q[i] <= '0;
        d2_q[i] <= '0;
      end
      sec_q <= '0;
    end else begin
      if (cmd_i.d1_wr) d1_q[sec_idx] <= rnd;
      if (cmd_i.d2_wr) d2_q[sec_idx] <= rnd;
      if (cmd_i.start) sec_q <= '0;
      else if (cmd_i.sec_inc) sec_q <= sec_q + 1'b1;
    end
  end

  // Q16.16 to saturated Q1.15, one guard bit so the top value cannot wrap
  logic signed [SigW:0] o_r;
  always_comb begin
    o_r = ((SigW+1)'(sig_q) + 33'sd1) >>> 1;
    if (o_r > 33'sd32767) result_o = 16'h7fff;
    else if (o_r < -33'sd32768) result_o = 16'h8000;
    else result_o = o_r[SampleW-1:0];
  end
endmodule
`default_nettype wire

FILE: dv/cbq_scoreboard.sv
`timescale 1ns / 1ps
module cbq_scoreboard (
  input  logic clk_i,
  input  logic rst_ni,
  cbq_in_if    in_ch,
  cbq_out_if   out_ch,
  cbq_cfg_if   cfg_ch,
  output int   mismatch_count_o,
  output int   pending_count_o,
  output int   samples_checked_o
);
  import cbq_pkg::*;

  // filter state mirrored on the checker side
  logic signed [CoefW-1:0] coefs [TableDepth];
  int                      stage_d1 [MaxSections];
  int                      stage_d2 [MaxSections];
  logic signed [CoefW-1:0] gain_q;
  logic [SecCfgW-1:0]      sections_q;
  logic [SampleW-1:0]      expected_samples [$];

  // round half up by 2^sh, clamp to 32 bits
  function automatic int round_clamp(input longint v, input int sh);
    longint r;
    begin
      r = (v + (longint'(1) << (sh - 1))) >>> sh;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return int'(r);
    end
  endfunction

  // run one sample through gain and active sections, updating delay state
  function automatic logic [SampleW-1:0] filter_sample(input logic signed [SampleW-1:0] x_in);
    int     sig;
    int     y;
    int     n;
    int     base;
    longint x;
    longint o;
    begin
      sig = round_clamp(longint'(x_in) * longint'(gain_q), 15);
      n = (sections_q > MaxSections) ? MaxSections : int'(sections_q);
      for (int s = 0; s < n; s++) begin
        base = s * TapsPerSection;
        x = sig;
        y = round_clamp(longint'(stage_d1[s]) * 65536 + longint'(coefs[base]) * x, 16);
        stage_d1[s] = round_clamp(longint'(stage_d2[s]) * 65536
                                  - longint'(coefs[base+3]) * longint'(y)
                                  + longint'(coefs[base+1]) * x, 16);
        stage_d2[s] = round_clamp(longint'(coefs[base+2]) * x
                                  - longint'(coefs[base+4]) * longint'(y), 16);
        sig = y;
      end
      o = (longint'(sig) + 1) >>> 1;
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      return o[SampleW-1:0];
    end
  endfunction

  assign pending_count_o = expected_samples.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MaxSections; s++) begin
        stage_d1[s] = 0;
        stage_d2[s] = 0;
      end
      for (int i = 0; i < TableDepth; i++) coefs[i] = '0;
      gain_q = 20'sd65536;
      sections_q = 4'd1;
      expected_samples.delete();
      mismatch_count_o = 0;
      samples_checked_o = 0;
    end else begin
      // result side first, so an item accepted now never matches itself
      if (out_ch.valid && out_ch.ready) begin
        samples_checked_o++;
        if (expected_samples.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%t unexpected result %0d", $realtime,
                     $signed(out_ch.filtered_sample));
        end else begin
          logic [SampleW-1:0] exp_s;
          exp_s = expected_samples.pop_front();
          if (exp_s !== out_ch.filtered_sample) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%t filtered_sample expected %0d got %0d", $realtime,
                       $signed(exp_s), $signed(out_ch.filtered_sample));
          end
        end
      end
      // config writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CfgGain) gain_q = cfg_ch.data;
        else sections_q = cfg_ch.data[SecCfgW-1:0];
      end
      // input items
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.mode == ModeCoef) begin
          if (in_ch.coef_index < TableDepth) coefs[in_ch.coef_index] = in_ch.coef_value;
        end else begin
          expected_samples.push_back(filter_sample(in_ch.sample));
        end
      end
    end
  end

endmodule

FILE: dv/cascaded_biquad_iir_filter_tb.sv
`timescale 1ns / 1ps
module cascaded_biquad_iir_filter_tb;
  import cbq_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady_flow = 1'b0;
  int   mismatch_count;
  int   pending_count;
  int   samples_checked;
  int   idle_cycles = 0;
  int   coef_writes = 0;

  localparam int IdleLimit = 2000;

  cbq_in_if  in_ch ();
  cbq_out_if out_ch ();
  cbq_cfg_if cfg_ch ();

  always #4 clk_i = ~clk_i;

  cascaded_biquad_iir_filter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cbq_scoreboard i_scoreboard (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_ch             (in_ch),
    .out_ch            (out_ch),
    .cfg_ch            (cfg_ch),
    .mismatch_count_o  (mismatch_count),
    .pending_count_o   (pending_count),
    .samples_checked_o (samples_checked)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = ModeFilter;
    in_ch.sample = '0;
    in_ch.coef_index = '0;
    in_ch.coef_value = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CfgGain;
    cfg_ch.data = '0;
  end

  // send one input item after a random gap, or none in steady flow
  task automatic send_item(input logic mode, input logic [15:0] smp,
                           input logic [5:0] idx, input logic [19:0] val);
    int gap;
    begin
      gap = steady_flow ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
        in_ch.valid = 1'b0;
        @(negedge clk_i);
      end
      in_ch.valid = 1'b1;
      in_ch.mode = mode;
      in_ch.sample = smp;
      in_ch.coef_index = idx;
      in_ch.coef_value = val;
      do @(posedge clk_i); while (!in_ch.ready);
      @(negedge clk_i);
      if (mode == ModeCoef) coef_writes++;
    end
  endtask

  task automatic send_sample(input logic [15:0] smp);
    send_item(ModeFilter, smp, 6'($urandom_range(0, 63)), 20'($urandom));
  endtask

  task automatic send_coef(input logic [5:0] idx, input logic [19:0] val);
    send_item(ModeCoef, 16'($urandom), idx, val);
  endtask

  // coefficient mostly modest, sometimes anywhere in Q4.16
  function automatic logic [19:0] pick_coef();
    if ($urandom_range(0, 3) == 0) return 20'($urandom);
    return 20'($signed($urandom_range(0, 65536)) - 32768);
  endfunction

  // wait until every result has drained, then a short settle
  task automatic drain();
    begin
      in_ch.valid = 1'b0;
      while (pending_count != 0) @(negedge clk_i);
      repeat (8) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [19:0] val);
    begin
      cfg_ch.valid = 1'b1;
      cfg_ch.index = idx;
      cfg_ch.data = val;
      do @(posedge clk_i); while (!cfg_ch.ready);
      @(negedge clk_i);
      cfg_ch.valid = 1'b0;
    end
  endtask

  task automatic configure(input logic [19:0] g, input logic [3:0] n);
    begin
      drain();
      write_reg(CfgGain, g);
      write_reg(CfgSections, {16'd0, n});
    end
  endtask

  // result side with random stalls, none in steady flow
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready = 1'b0;
      repeat (steady_flow ? 0 : $urandom_range(0, 6)) @(negedge clk_i);
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired with %0d results outstanding", pending_count);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [19:0] gains [5];
    logic [3:0]  secs [5];
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // fill the whole table before any sample reads it
    for (int i = 0; i < TableDepth; i++) send_coef(6'(i), pick_coef());
    // extremes at reset settings, one section
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hffff);
    // full-scale gain and every section
    configure(20'h80000, 4'd8);
    send_coef(6'd0, 20'h7ffff);
    send_coef(6'd39, 20'h80000);
    send_coef(6'd40, 20'h12345);
    send_coef(6'd63, 20'hfffff);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    // gain only
    configure(20'h7ffff, 4'd0);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0001);
    // section count beyond the maximum clamps
    configure(20'h10000, 4'd15);
    send_sample(16'h4000);
    send_sample(16'hc000);

    gains = '{20'h10000, 20'h80000, 20'h7ffff, 20'h08000, 20'hf0000};
    secs = '{4'd1, 4'd8, 4'd0, 4'd3, 4'd15};
    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 5) configure(gains[ph], secs[ph]);
      else configure(20'($urandom), 4'($urandom_range(0, 15)));
      steady_flow = (ph % 4 == 3);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(0, 9) == 0) send_coef(6'($urandom_range(0, 63)), pick_coef());
        else if ($urandom_range(0, 4) == 0) send_sample(16'($urandom));
        else send_sample(16'($signed($urandom_range(0, 16383)) - 8192));
      end
      steady_flow = 1'b0;
    end

    drain();
    repeat (100) @(negedge clk_i);
    $display("run covered %0d filtered samples and %0d coefficient writes", samples_checked,
             coef_writes);
    $display("over gain-only, one to eight sections, clamped counts and full-scale gains");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
